// ===== sv/hcbp_pkg.sv =====
package hcbp_pkg;

  localparam int unsigned SYMBOL_COUNT = 128;
  localparam int unsigned SYM_W        = 7;
  localparam int unsigned CODE_W       = 32;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned MAX_CODE_LEN = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CNT_W        = 3;
  localparam int unsigned SHIFT_W      = CODE_W + BYTE_W;
  localparam int unsigned TOTAL_W      = 6;

  // Stored lengths saturate to the smaller of the code limit and the table width.
  localparam int unsigned LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_ENCODE = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } code_entry_t;

endpackage

// ===== sv/hcbp_in_if.sv =====
interface hcbp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [hcbp_pkg::SYM_W-1:0]   symbol;
  logic [hcbp_pkg::CODE_W-1:0]  code_bits;
  logic [hcbp_pkg::LEN_W-1:0]   code_length;

  modport source (output valid, action, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, action, symbol, code_bits, code_length, output ready);
endinterface

// ===== sv/hcbp_out_if.sv =====
interface hcbp_out_if;
  logic                         valid;
  logic                         ready;
  logic [hcbp_pkg::BYTE_W-1:0]  packed_byte;
  logic                         last_of_run;

  modport source (output valid, packed_byte, last_of_run, input ready);
  modport sink   (input valid, packed_byte, last_of_run, output ready);
endinterface

// ===== sv/huffman_code_bit_packer_unit.sv =====
// Huffman bit packer with a 128-entry code table held in a synchronous RAM.
// A load word writes one symbol's code and length (lengths above 32 saturate)
// in the cycle it is accepted. An encode word completes 0 to 4 bytes: it is
// accepted and issues the table read, the registered RAM data merges with the
// pending bits, then one byte per cycle leaves the output register, each held
// until taken. The input is ready only while no item is in flight. Bytes are
// packed first code bit first into bit 7; the last byte of an encode carries
// last_of_run. Leftover partial bits stay pending and are never flushed.
// Encoding a symbol that was never loaded yields undefined bytes.
module huffman_code_bit_packer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbp_in_if.sink    in_i,
  hcbp_out_if.source out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  hcbp_pkg::code_entry_t mem_q [hcbp_pkg::SYMBOL_COUNT];
  hcbp_pkg::code_entry_t rd_data_q;
  hcbp_pkg::code_entry_t wr_entry;

  logic [1:0]                       state_q, state_d;
  logic [hcbp_pkg::BYTE_W-1:0]      acc_q, acc_d;
  logic [hcbp_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [hcbp_pkg::SHIFT_W-1:0]     sh_q, sh_d;
  logic [hcbp_pkg::TOTAL_W-1:0]     total_q, total_d;

  logic                             in_fire, out_fire;
  logic [hcbp_pkg::CODE_W-1:0]      code_al;
  logic [hcbp_pkg::SHIFT_W-1:0]     merged;
  logic [hcbp_pkg::TOTAL_W-1:0]     merged_total;
  logic [hcbp_pkg::TOTAL_W-1:0]     rest_total;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  always_comb begin
    wr_entry.code = in_i.code_bits;
    if (in_i.code_length > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT)) begin
      wr_entry.len = hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT);
    end else begin
      wr_entry.len = in_i.code_length;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.action == hcbp_pkg::ACT_LOAD) begin
      mem_q[in_i.symbol] <= wr_entry;
    end
    if (in_fire && in_i.action == hcbp_pkg::ACT_ENCODE) begin
      rd_data_q <= mem_q[in_i.symbol];
    end
  end

  // Left-align the code, then slide it under the pending bits, which are
  // kept left-aligned in acc_q with zeros below.
  assign code_al = rd_data_q.code << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - rd_data_q.len);
  assign merged  = {acc_q, {hcbp_pkg::CODE_W{1'b0}}}
                 | ({code_al, {hcbp_pkg::BYTE_W{1'b0}}} >> cnt_q);
  assign merged_total = hcbp_pkg::TOTAL_W'(cnt_q) + hcbp_pkg::TOTAL_W'(rd_data_q.len);
  assign rest_total   = total_q - hcbp_pkg::TOTAL_W'(hcbp_pkg::BYTE_W);

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    sh_d    = sh_q;
    total_d = total_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_i.action == hcbp_pkg::ACT_ENCODE) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        sh_d    = merged;
        total_d = merged_total;
        if (merged_total < hcbp_pkg::TOTAL_W'(hcbp_pkg::BYTE_W)) begin
          acc_d   = merged[hcbp_pkg::SHIFT_W-1 -: hcbp_pkg::BYTE_W];
          cnt_d   = merged_total[hcbp_pkg::CNT_W-1:0];
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          // advance to the next byte; the leftover bits become the pending bits
          sh_d    = sh_q << hcbp_pkg::BYTE_W;
          total_d = rest_total;
          if (rest_total < hcbp_pkg::TOTAL_W'(hcbp_pkg::BYTE_W)) begin
            acc_d   = sh_q[hcbp_pkg::SHIFT_W-hcbp_pkg::BYTE_W-1 -: hcbp_pkg::BYTE_W];
            cnt_d   = rest_total[hcbp_pkg::CNT_W-1:0];
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign out_o.valid       = (state_q == ST_EMIT);
  assign out_o.packed_byte = sh_q[hcbp_pkg::SHIFT_W-1 -: hcbp_pkg::BYTE_W];
  assign out_o.last_of_run = (rest_total < hcbp_pkg::TOTAL_W'(hcbp_pkg::BYTE_W));

  a_emit_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (total_q >= hcbp_pkg::TOTAL_W'(hcbp_pkg::BYTE_W)))
    else $error("byte presented with fewer than eight bits pending");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while bytes are still being emitted");

  a_encode_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.action == hcbp_pkg::ACT_ENCODE)
      |=> (state_q == ST_READ))
    else $error("encode word did not start a table read");

  a_pending_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !out_o.last_of_run) |=> $stable(cnt_q) && $stable(acc_q))
    else $error("pending bits changed before the last byte");

endmodule

// ===== verif/huffman_code_bit_packer_unit_tb.sv =====
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit_tb;

  typedef struct packed {
    logic                          action;
    logic [hcbp_pkg::SYM_W-1:0]    symbol;
    logic [hcbp_pkg::CODE_W-1:0]   code_bits;
    logic [hcbp_pkg::LEN_W-1:0]    code_length;
  } in_word_t;

  typedef struct packed {
    logic [hcbp_pkg::BYTE_W-1:0] value;
    logic                        ends_run;
  } due_byte_t;

  class packed_byte_tracker;
    bit [hcbp_pkg::CODE_W-1:0] code_mem [hcbp_pkg::SYMBOL_COUNT];
    bit [hcbp_pkg::LEN_W-1:0]  len_mem [hcbp_pkg::SYMBOL_COUNT];
    bit                        loaded [hcbp_pkg::SYMBOL_COUNT];
    bit [hcbp_pkg::SYM_W-1:0]  loaded_list [$];
    bit [hcbp_pkg::BYTE_W-1:0] acc;
    int                        fill;
    due_byte_t                 due_bytes [$];
    int                        mismatches;

    function void note_word(in_word_t w);
      bit [hcbp_pkg::LEN_W-1:0]  n;
      bit [hcbp_pkg::CODE_W-1:0] c;
      int                        made;
      if (w.action == hcbp_pkg::ACT_LOAD) begin
        n = w.code_length;
        if (n > hcbp_pkg::LEN_LIMIT) n = hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT);
        code_mem[w.symbol] = w.code_bits;
        len_mem[w.symbol]  = n;
        if (!loaded[w.symbol]) begin
          loaded[w.symbol] = 1'b1;
          loaded_list.push_back(w.symbol);
        end
        return;
      end
      c    = code_mem[w.symbol];
      n    = len_mem[w.symbol];
      made = 0;
      // shift the code in, first code bit first
      for (int i = n; i > 0; i--) begin
        acc = {acc[hcbp_pkg::BYTE_W-2:0], c[i-1]};
        fill++;
        if (fill == hcbp_pkg::BYTE_W) begin
          due_bytes.push_back('{value: acc, ends_run: 1'b0});
          made++;
          acc  = '0;
          fill = 0;
        end
      end
      if (made > 0) due_bytes[$].ends_run = 1'b1;
    endfunction

    task report(string what, logic [hcbp_pkg::BYTE_W-1:0] got,
                logic [hcbp_pkg::BYTE_W-1:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_byte(logic [hcbp_pkg::BYTE_W-1:0] value, logic ends_run);
      due_byte_t want;
      if (due_bytes.size() == 0) begin
        report("unexpected byte", value, '0);
        return;
      end
      want = due_bytes.pop_front();
      if (value !== want.value) report("packed_byte", value, want.value);
      if (ends_run !== want.ends_run) report("last_of_run", ends_run, want.ends_run);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  hcbp_in_if  in_bus ();
  hcbp_out_if out_bus ();

  huffman_code_bit_packer_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  packed_byte_tracker tracker = new;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_go        = 1'b0;
  bit hold_on        = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hold off the receiver for a fixed number of cycles once requested.
  initial begin
    wait (hold_go);
    hold_on = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_on = 1'b0;
  end

  // Byte receiver: check what is taken, then pick next ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      tracker.check_byte(out_bus.packed_byte, out_bus.last_of_run);
    if (hold_on) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.action      <= w.action;
    in_bus.symbol      <= w.symbol;
    in_bus.code_bits   <= w.code_bits;
    in_bus.code_length <= w.code_length;
    do @(posedge clk_i); while (!in_bus.ready);
    tracker.note_word(w);
  endtask

  task send_fields(logic action, int symbol, logic [hcbp_pkg::CODE_W-1:0] bits, int len);
    send_word('{action: action, symbol: symbol[hcbp_pkg::SYM_W-1:0], code_bits: bits,
                code_length: len[hcbp_pkg::LEN_W-1:0]});
  endtask

  // Mostly encodes of loaded symbols; loads favor short codes.
  function automatic in_word_t make_word();
    in_word_t w;
    int       pick;
    w.code_bits = $urandom;
    pick        = $urandom_range(99);
    if (tracker.loaded_list.size() == 0 || pick < 20) begin
      w.action = hcbp_pkg::ACT_LOAD;
      w.symbol = hcbp_pkg::SYM_W'($urandom_range(hcbp_pkg::SYMBOL_COUNT - 1));
      pick     = $urandom_range(99);
      if (pick < 70) w.code_length = hcbp_pkg::LEN_W'($urandom_range(12));
      else if (pick < 90) w.code_length = hcbp_pkg::LEN_W'($urandom_range(32, 13));
      else w.code_length = hcbp_pkg::LEN_W'($urandom_range(63, 33));
    end else begin
      w.action      = hcbp_pkg::ACT_ENCODE;
      w.symbol      = tracker.loaded_list[$urandom_range(tracker.loaded_list.size() - 1)];
      w.code_length = hcbp_pkg::LEN_W'($urandom);
    end
    return w;
  endfunction

  task send_random(int count);
    for (int k = 0; k < count; k++) send_word(make_word());
  endtask

  initial begin
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.action      <= hcbp_pkg::ACT_LOAD;
    in_bus.symbol      <= '0;
    in_bus.code_bits   <= '0;
    in_bus.code_length <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: table extremes, saturation, excess bits, zero length
    send_fields(hcbp_pkg::ACT_LOAD, 0, 32'hDEADBEEF, 0);
    send_fields(hcbp_pkg::ACT_LOAD, 127, 32'hFFFFFFFF, 32);
    send_fields(hcbp_pkg::ACT_LOAD, 1, 32'h0, 1);
    send_fields(hcbp_pkg::ACT_LOAD, 2, 32'hFFFFFFF5, 4);
    send_fields(hcbp_pkg::ACT_LOAD, 64, 32'h12345678, 63);
    send_fields(hcbp_pkg::ACT_LOAD, 3, 32'h1, 1);
    send_fields(hcbp_pkg::ACT_LOAD, 4, 32'h2A, 7);
    send_fields(hcbp_pkg::ACT_ENCODE, 0, 32'h0, 0);
    send_fields(hcbp_pkg::ACT_ENCODE, 127, 32'h0, 63);
    send_fields(hcbp_pkg::ACT_ENCODE, 3, 32'hFFFFFFFF, 0);
    send_fields(hcbp_pkg::ACT_ENCODE, 0, 32'h0, 0);
    send_fields(hcbp_pkg::ACT_ENCODE, 64, 32'h0, 0);
    send_fields(hcbp_pkg::ACT_ENCODE, 4, 32'h0, 0);
    send_fields(hcbp_pkg::ACT_ENCODE, 2, 32'h0, 0);
    send_fields(hcbp_pkg::ACT_ENCODE, 1, 32'h0, 0);
    send_fields(hcbp_pkg::ACT_ENCODE, 2, 32'h0, 0);
    send_fields(hcbp_pkg::ACT_ENCODE, 1, 32'h0, 0);
    send_fields(hcbp_pkg::ACT_LOAD, 127, 32'h0, 32);
    send_fields(hcbp_pkg::ACT_ENCODE, 127, 32'h0, 0);
    send_fields(hcbp_pkg::ACT_LOAD, 5, 32'hAAAAAAAA, 33);
    send_fields(hcbp_pkg::ACT_ENCODE, 5, 32'h0, 0);

    send_random(100);
    send_idle_pct = 76;
    send_random(100);
    send_idle_pct  = 0;
    recv_stall_pct = 76;
    send_random(100);
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    send_random(100);

    // long receiver hold-off with a busy sender so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b1;
    send_random(30);
    in_bus.valid <= 1'b0;

    for (int k = 0; k < 5000 && tracker.due_bytes.size() != 0; k++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    while (tracker.due_bytes.size() != 0) begin
      tracker.report("missing byte", 'x, tracker.due_bytes[0].value);
      void'(tracker.due_bytes.pop_front());
    end
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout waiting for the packer");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
